>>> rtl/core/assert_macros.svh
// Assertion macros used by the RTL datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property on every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

>>> rtl/core/ssm_pkg.sv
// Shared types and constants of the sorted stream merge block.
package ssm_pkg;

  localparam int unsigned ValueW = 32;

  localparam logic STATUS_MERGED  = 1'b0;
  localparam logic STATUS_DROPPED = 1'b1;

  localparam logic LIST_FIRST  = 1'b0;
  localparam logic LIST_SECOND = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;   // capture the accepted input word
    logic push;        // write the held item into its FIFO
    logic drop_out;    // send a drop report
    logic mark_end;    // record the final mark of the held item
    logic read_heads;  // fetch both FIFO heads
    logic emit;        // pop the smaller head and send it
    logic rearm;       // clear both end flags
  } ssm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic drop;        // held item cannot be stored
    logic can_emit;    // a head may be sent now
    logic all_done;    // both lists ended, nothing pending
    logic out_free;    // output register can take a word
    logic eom_next;    // the pending emit closes the merge
  } ssm_sts_t;

endpackage

>>> rtl/core/ssm_ctrl.sv
// Controller state machine of the sorted stream merge block.
module ssm_ctrl
  import ssm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  ssm_sts_t sts_i,
  output ssm_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PUSH,
    S_READ,
    S_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   ready_q, ready_d;

  always_comb begin
    state_d = state_q;
    ready_d = 1'b0;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && ready_q) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_PUSH;
        end else begin
          ready_d = 1'b1;
        end
      end
      S_PUSH: begin
        if (sts_i.drop) begin
          // hold until the drop report can leave
          if (sts_i.out_free) begin
            cmd_o.drop_out = 1'b1;
            cmd_o.mark_end = 1'b1;
            state_d        = S_READ;
          end
        end else begin
          cmd_o.push     = 1'b1;
          cmd_o.mark_end = 1'b1;
          state_d        = S_READ;
        end
      end
      S_READ: begin
        if (sts_i.can_emit) begin
          cmd_o.read_heads = 1'b1;
          state_d          = S_EMIT;
        end else begin
          cmd_o.rearm = sts_i.all_done;
          ready_d     = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.eom_next) begin
            ready_d = 1'b1;
            state_d = S_IDLE;
          end else begin
            state_d = S_READ;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ready_q <= 1'b1;
    end else begin
      state_q <= state_d;
      ready_q <= ready_d;
    end
  end

  assign in_ready_o = ready_q;

endmodule

>>> rtl/core/ssm_datapath.sv
// Datapath of the sorted stream merge block: FIFOs, head compare, output register.
`include "assert_macros.svh"
module ssm_datapath
  import ssm_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ssm_cmd_t                 cmd_i,
  output ssm_sts_t                 sts_o,
  input  logic                     in_op_i,
  input  logic signed [ValueW-1:0] in_value_i,
  input  logic                     in_final_i,
  input  logic                     out_ready_i,
  output logic                     out_valid_o,
  output logic                     out_status_o,
  output logic signed [ValueW-1:0] out_value_o,
  output logic                     out_source_o,
  output logic                     out_eom_o
);

  localparam int unsigned PtrW = $clog2(FIFO_DEPTH);
  localparam int unsigned CntW = $clog2(FIFO_DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(FIFO_DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(FIFO_DEPTH);
  localparam logic [CntW-1:0] CntOne  = CntW'(1);

  logic signed [ValueW-1:0] mem_first [FIFO_DEPTH];
  logic signed [ValueW-1:0] mem_second[FIFO_DEPTH];

  logic                     item_op_q;
  logic signed [ValueW-1:0] item_value_q;
  logic                     item_final_q;

  logic [PtrW-1:0] rptr_first_q, wptr_first_q, rptr_second_q, wptr_second_q;
  logic [CntW-1:0] cnt_first_q, cnt_second_q;
  logic            ended_first_q, ended_second_q;

  logic signed [ValueW-1:0] head_first_q, head_second_q;

  logic                     out_valid_q;
  logic                     out_status_q;
  logic signed [ValueW-1:0] out_value_q;
  logic                     out_source_q;
  logic                     out_eom_q;

  logic take_first;
  logic first_empty, second_empty;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    ptr_next = (p == PtrLast) ? '0 : p + PtrW'(1);
  endfunction

  assign first_empty  = (cnt_first_q == '0);
  assign second_empty = (cnt_second_q == '0);

  // Ties go to the first list; a single nonempty FIFO wins alone.
  assign take_first = !first_empty && (second_empty || (head_first_q <= head_second_q));

  always_comb begin
    sts_o.drop     = item_op_q ? (ended_second_q || cnt_second_q == CntFull)
                               : (ended_first_q  || cnt_first_q  == CntFull);
    sts_o.can_emit = (!first_empty && !second_empty) ||
                     (!first_empty && ended_second_q) ||
                     (!second_empty && ended_first_q);
    sts_o.all_done = ended_first_q && ended_second_q && first_empty && second_empty;
    sts_o.out_free = !out_valid_q || out_ready_i;
    sts_o.eom_next = ended_first_q && ended_second_q &&
                     (take_first ? (cnt_first_q == CntOne && second_empty)
                                 : (cnt_second_q == CntOne && first_empty));
  end

  // Item holding register, FIFO storage and head registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_op_q    <= in_op_i;
      item_value_q <= in_value_i;
      item_final_q <= in_final_i;
    end
    if (cmd_i.push && item_op_q == LIST_FIRST) begin
      mem_first[wptr_first_q] <= item_value_q;
    end
    if (cmd_i.push && item_op_q == LIST_SECOND) begin
      mem_second[wptr_second_q] <= item_value_q;
    end
    if (cmd_i.read_heads) begin
      head_first_q  <= mem_first[rptr_first_q];
      head_second_q <= mem_second[rptr_second_q];
    end
  end

  // Pointers, counts and end flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rptr_first_q   <= '0;
      wptr_first_q   <= '0;
      cnt_first_q    <= '0;
      rptr_second_q  <= '0;
      wptr_second_q  <= '0;
      cnt_second_q   <= '0;
      ended_first_q  <= 1'b0;
      ended_second_q <= 1'b0;
    end else begin
      if (cmd_i.push) begin
        if (item_op_q == LIST_FIRST) begin
          wptr_first_q <= ptr_next(wptr_first_q);
          cnt_first_q  <= cnt_first_q + CntOne;
        end else begin
          wptr_second_q <= ptr_next(wptr_second_q);
          cnt_second_q  <= cnt_second_q + CntOne;
        end
      end
      if (cmd_i.mark_end && item_final_q) begin
        if (item_op_q == LIST_FIRST) begin
          ended_first_q <= 1'b1;
        end else begin
          ended_second_q <= 1'b1;
        end
      end
      if (cmd_i.emit) begin
        if (take_first) begin
          rptr_first_q <= ptr_next(rptr_first_q);
          cnt_first_q  <= cnt_first_q - CntOne;
        end else begin
          rptr_second_q <= ptr_next(rptr_second_q);
          cnt_second_q  <= cnt_second_q - CntOne;
        end
      end
      if (cmd_i.rearm || (cmd_i.emit && sts_o.eom_next)) begin
        ended_first_q  <= 1'b0;
        ended_second_q <= 1'b0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.drop_out || cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.drop_out) begin
      out_status_q <= STATUS_DROPPED;
      out_value_q  <= '0;
      out_source_q <= LIST_FIRST;
      out_eom_q    <= 1'b0;
    end else if (cmd_i.emit) begin
      out_status_q <= STATUS_MERGED;
      out_value_q  <= take_first ? head_first_q : head_second_q;
      out_source_q <= take_first ? LIST_FIRST : LIST_SECOND;
      out_eom_q    <= sts_o.eom_next;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_value_o  = out_value_q;
  assign out_source_o = out_source_q;
  assign out_eom_o    = out_eom_q;

  `ASSERT_PROP(a_cnt_bound, clk_i, rst_ni, (cnt_first_q <= CntFull) && (cnt_second_q <= CntFull))
  `ASSERT_NEVER(a_push_blocked, clk_i, rst_ni, cmd_i.push && sts_o.drop)
  `ASSERT_PROP(a_load_free, clk_i, rst_ni, (cmd_i.emit || cmd_i.drop_out) |-> sts_o.out_free)
  `ASSERT_PROP(a_emit_nonempty, clk_i, rst_ni, cmd_i.emit |-> (!first_empty || !second_empty))

endmodule

>>> rtl/core/sorted_stream_merge.sv
// Sorted stream merge: joins two ascending signed 32-bit lists into one.
//
// Input stream (s_axis): one word per element. tdata carries the value, tuser
// selects the list (0 first, 1 second), tlast marks the final element of that
// list. The two lists may interleave in any order.
// Output stream (m_axis): tdata is the merged value (zero for a drop report),
// tuser[0] is the status (0 merged, 1 input dropped), tuser[1] the source list,
// and tlast marks the last word of the merged sequence; the block then rearms.
// Ties go to the first list. An element sent to a full FIFO, or to a list that
// has already ended, is dropped and reported by one status word.
// Timing: one element at a time. A word is stored and tested (push, then head
// test), then each merged word it releases takes a head fetch, then compare
// and pop. tready stays low until all merged words it releases are sent; a
// stalled output holds it low longer.
// Reset clears FIFO pointers, counts, end flags and the output valid flag.
// A stall on m_axis_tready_i holds the output word and freezes the merge until
// the word is taken; input is not taken while a merge step is pending.
module sorted_stream_merge
  import ssm_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] value
  input  logic [0:0]  s_axis_tuser_i,   // [0] op
  input  logic        s_axis_tlast_i,   // is_final
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] merged_value
  output logic [1:0]  m_axis_tuser_o,   // [0] status, [1] source_list
  output logic        m_axis_tlast_o    // end_of_merge
);

  ssm_cmd_t cmd;
  ssm_sts_t sts;

  logic                     out_status;
  logic                     out_source;
  logic signed [ValueW-1:0] out_value;

  // Sequence the accept, push, head fetch and emit steps.
  ssm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Hold both FIFOs, compare heads and drive the output word.
  ssm_datapath #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_op_i      (s_axis_tuser_i[0]),
    .in_value_i   ($signed(s_axis_tdata_i)),
    .in_final_i   (s_axis_tlast_i),
    .out_ready_i  (m_axis_tready_i),
    .out_valid_o  (m_axis_tvalid_o),
    .out_status_o (out_status),
    .out_value_o  (out_value),
    .out_source_o (out_source),
    .out_eom_o    (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = $unsigned(out_value);
  assign m_axis_tuser_o = {out_source, out_status};

endmodule

>>> bench/testbench.sv
// Self-checking bench for the sorted stream merge: directed and random lists.
`timescale 1ns / 100ps

localparam int FifoDepth = 16;

typedef struct packed {
  logic        status;
  logic [31:0] value;
  logic        src;
  logic        eom;
} merge_word_t;

// Tracks both pending lists and the merged words that must come out next.
class merge_order_board;
  logic [31:0] first_q[$];
  logic [31:0] second_q[$];
  logic        first_done;
  logic        second_done;
  merge_word_t due_words[$];
  int          errors;

  function new();
    first_done  = 1'b0;
    second_done = 1'b0;
    errors      = 0;
  endfunction

  task report_mismatch(string msg);
    if (errors < 30) $display("[%0t] MISMATCH: %s", $realtime, msg);
    errors++;
  endtask

  function void push_drop();
    merge_word_t w;
    w.status = ssm_pkg::STATUS_DROPPED;
    w.value  = '0;
    w.src    = ssm_pkg::LIST_FIRST;
    w.eom    = 1'b0;
    due_words.push_back(w);
  endfunction

  // Store one accepted element, then release every head that may go out.
  function void note_element(logic op, logic [31:0] val, logic fin);
    merge_word_t w;
    logic        take_first;
    if (op == ssm_pkg::LIST_FIRST) begin
      if (first_done || first_q.size() >= FifoDepth) push_drop();
      else first_q.push_back(val);
      if (fin) first_done = 1'b1;
    end else begin
      if (second_done || second_q.size() >= FifoDepth) push_drop();
      else second_q.push_back(val);
      if (fin) second_done = 1'b1;
    end
    while (1) begin
      if (first_q.size() > 0 && second_q.size() > 0)
        take_first = $signed(first_q[0]) <= $signed(second_q[0]);
      else if (first_q.size() > 0 && second_done)
        take_first = 1'b1;
      else if (second_q.size() > 0 && first_done)
        take_first = 1'b0;
      else
        break;
      w.status = ssm_pkg::STATUS_MERGED;
      if (take_first) begin
        w.value = first_q.pop_front();
        w.src   = ssm_pkg::LIST_FIRST;
      end else begin
        w.value = second_q.pop_front();
        w.src   = ssm_pkg::LIST_SECOND;
      end
      w.eom = first_done && second_done && first_q.size() == 0 && second_q.size() == 0;
      due_words.push_back(w);
      if (w.eom) begin
        first_done  = 1'b0;
        second_done = 1'b0;
        break;
      end
    end
    // both lists closed with nothing left: rearm without a word
    if (first_done && second_done && first_q.size() == 0 && second_q.size() == 0) begin
      first_done  = 1'b0;
      second_done = 1'b0;
    end
  endfunction

  task check_word(logic [31:0] data, logic [1:0] user, logic last);
    merge_word_t w;
    if (due_words.size() == 0) begin
      report_mismatch($sformatf("unexpected word data=%h user=%b last=%b", data, user, last));
      return;
    end
    w = due_words.pop_front();
    if (user[0] !== w.status)
      report_mismatch($sformatf("status %b, want %b", user[0], w.status));
    if (data !== w.value)
      report_mismatch($sformatf("merged value %h, want %h", data, w.value));
    if (user[1] !== w.src)
      report_mismatch($sformatf("source list %b, want %b", user[1], w.src));
    if (last !== w.eom)
      report_mismatch($sformatf("end of merge %b, want %b (value %h)", last, w.eom, w.value));
  endtask
endclass

module testbench;
  import ssm_pkg::*;

  localparam int RandomItems = 84;
  localparam int QuietLimit  = 3000;
  localparam int DrainCycles = 60;

  logic        clk_i = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_ready;
  logic [31:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        s_tlast = 1'b0;
  logic        m_valid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  int src_idle = 0;
  int dst_idle = 0;
  int words_sent = 0;
  int quiet_cycles = 0;

  merge_order_board board = new();

  sorted_stream_merge #(.FIFO_DEPTH(FifoDepth)) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver stalls at random, one decision per cycle.
  always @(negedge clk_i) begin
    m_tready <= ($urandom_range(99) >= dst_idle);
  end

  // Record accepted elements before checking results of the same edge.
  always @(posedge clk_i) begin
    if (rst_n) begin
      if (s_tvalid && s_ready) board.note_element(s_tuser[0], s_tdata, s_tlast);
      if (m_valid && m_tready) board.check_word(m_tdata, m_tuser, m_tlast);
      if ((s_tvalid && s_ready) || (m_valid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("sorted_stream_merge test failed");
        $finish;
      end
    end
  end

  task automatic send_word(input logic op, input logic [31:0] val, input logic fin);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid   <= 1'b1;
    s_tdata    <= val;
    s_tuser[0] <= op;
    s_tlast    <= fin;
    do @(posedge clk_i); while (!s_ready);
    words_sent++;
  endtask

  // Hold the input quiet until every due word has come out.
  task automatic hold_until_drained();
    @(negedge clk_i);
    s_tvalid <= 1'b0;
    while (board.due_words.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(3))
      0:       return 32'($signed($urandom_range(8)) - 4);  // near zero, many ties
      1:       return $urandom_range(1) ? 32'h8000_0000 + $urandom_range(3)
                                        : 32'h7fff_ffff - $urandom_range(3);
      default: return $urandom;
    endcase
  endfunction

  // One pair of lists, interleaved at random; some pairs are malformed on purpose.
  task automatic send_list_pair();
    int          list_a[$];
    int          list_b[$];
    int          len_a;
    int          len_b;
    int          flavor;
    int          stray_at;
    int          n;
    logic        op;
    logic [31:0] val;
    logic        fin;
    flavor = $urandom_range(9);
    if (flavor == 0) begin
      // noise: random tags, values and final marks
      repeat ($urandom_range(4, 1))
        send_word(1'($urandom_range(1)), $urandom, ($urandom_range(3) == 0));
      return;
    end
    len_a = ($urandom_range(7) == 0) ? $urandom_range(FifoDepth + 2, 8) : $urandom_range(5, 1);
    len_b = ($urandom_range(7) == 0) ? $urandom_range(FifoDepth + 2, 8) : $urandom_range(5, 1);
    repeat (len_a) list_a.push_back(int'(pick_value()));
    repeat (len_b) list_b.push_back(int'(pick_value()));
    if (flavor != 1) begin
      list_a.sort();
      list_b.sort();
    end
    stray_at = (flavor == 2) ? $urandom_range(len_a + len_b - 1) : -1;
    n = 0;
    while (list_a.size() > 0 || list_b.size() > 0) begin
      if (list_a.size() == 0) op = LIST_SECOND;
      else if (list_b.size() == 0) op = LIST_FIRST;
      else op = $urandom_range(1) ? LIST_SECOND : LIST_FIRST;
      if (op == LIST_FIRST) begin
        val = list_a.pop_front();
        fin = (list_a.size() == 0);
      end else begin
        val = list_b.pop_front();
        fin = (list_b.size() == 0);
      end
      send_word(op, val, fin);
      // broken pair: an extra element lands on a list that may have ended
      if (n == stray_at) send_word(1'($urandom_range(1)), pick_value(), 1'b0);
      n++;
    end
  endtask

  initial begin
    int target;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_n = 1'b1;

    src_idle = 28;
    dst_idle = 77;
    // Fill the first FIFO with no partner, then overflow it on its final element.
    for (int i = 0; i < FifoDepth; i++) send_word(LIST_FIRST, 32'h8000_0000 + i, 1'b0);
    send_word(LIST_FIRST, 32'h7fff_ffff, 1'b1);   // dropped, list still ends
    send_word(LIST_FIRST, 32'h0000_0000, 1'b0);   // list already ended: dropped
    send_word(LIST_SECOND, 32'h8000_0000, 1'b0);  // ties with first head
    send_word(LIST_SECOND, 32'h7fff_ffff, 1'b1);  // drains both FIFOs
    // second list ends first, then the first list
    send_word(LIST_SECOND, 32'hffff_ffff, 1'b1);
    send_word(LIST_FIRST, 32'h0000_0000, 1'b1);
    // one-element lists at the top value, tie goes to the first list
    send_word(LIST_FIRST, 32'h7fff_ffff, 1'b1);
    send_word(LIST_SECOND, 32'h7fff_ffff, 1'b1);
    hold_until_drained();

    for (int phase = 0; phase < 3; phase++) begin
      src_idle = (phase == 0) ? 28 : (phase == 1) ? 77 : 0;
      dst_idle = (phase == 0) ? 77 : (phase == 1) ? 28 : 0;
      target = words_sent + RandomItems / 3;
      while (words_sent < target) send_list_pair();
      hold_until_drained();
    end

    repeat (DrainCycles) @(posedge clk_i);
    while (board.due_words.size() != 0) begin
      board.report_mismatch("expected word never arrived");
      void'(board.due_words.pop_front());
    end
    if (board.errors == 0) $display("sorted_stream_merge test passed");
    else $display("sorted_stream_merge test failed");
    $finish;
  end
endmodule

>>> sorted_stream_merge.f
+incdir+rtl/core
rtl/core/ssm_pkg.sv
rtl/core/ssm_ctrl.sv
rtl/core/ssm_datapath.sv
rtl/core/sorted_stream_merge.sv
bench/testbench.sv
